@@ hdl/dwsp_pkg.sv @@
// Package with shared types and constants of the dual wheel speed PID.
`timescale 1ns / 1ps
package dwsp_pkg;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_KP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI_S = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI_M = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KI_L = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TH_S = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TH_L = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd7;

    localparam logic [22:0] TH_S_RESET = 23'd1280;
    localparam logic [22:0] TH_L_RESET = 23'd2560;

    typedef struct packed {
        logic signed [15:0] left_counts;
        logic signed [15:0] right_counts;
        logic        [15:0] interval_ms;
        logic signed [23:0] left_target;
        logic signed [23:0] right_target;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] left_drive;
        logic signed [31:0] right_drive;
        logic signed [23:0] left_speed;
        logic signed [23:0] right_speed;
        logic               saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SPEED,
        ST_ERR,
        ST_TERM,
        ST_ACC,
        ST_OUT
    } state_t;

    // Division request/response between top level and divider.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;
endpackage

@@ hdl/dwsp_if.sv @@
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface dwsp_if #(
    parameter int unsigned W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/dwsp_div.sv @@
// Restoring radix-2 divider for magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps
module dwsp_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dwsp_pkg::div_ctrl_t   ctrl,
    input  logic [39:0]           dividend,
    input  logic [15:0]           divisor,
    output logic [39:0]           quotient,
    output dwsp_pkg::div_stat_t   stat
);
    logic [39:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [16:0] shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[15:0], quo_reg[39]};
        trial     = shifted - {1'b0, dvs_reg};
        if (ctrl.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 6'd40;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[16])
            begin
                rem_next = trial;
                quo_next = {quo_reg[38:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[38:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

@@ hdl/dual_wheel_speed_pid.sv @@
// Top level of the dual wheel speed PID controller.
//
// One request on the input channel carries both encoder count changes, the
// interval in ms and both target speeds. One request on the output channel
// returns both accumulated drives, both measured speeds and a clip flag.
// Write the configuration registers (cfg_we/cfg_idx/cfg_data) only while
// idle; the block won't enforce it. Indexes beyond the list are ignored.
//
// Work is sequenced through one shared 40-bit restoring divider (one bit
// per cycle) and one shared 27x25 multiplier, used for each wheel speed
// product and once per PID term. Each wheel speed takes a product step, a
// divider start, a wait on the 40-step divider and a clip step. Each
// wheel's PID then takes an error step, multiply-accumulate steps for the
// P, I and D terms and an accumulate step, and a last step loads the
// output register. A new request is taken only after that, as in.ready is
// high only while idle. A waiting result does not block the next request,
// but that request then holds in the last state until the pending result
// is taken. Reset clears the accumulators, error history and control state
// and loads the register defaults (thresholds 5.0 and 10.0, all gains and
// scale zero).
`timescale 1ns / 1ps
module dual_wheel_speed_pid (
    input  logic                               clk,
    input  logic                               rst_n,
    dwsp_if.sink                               in,
    dwsp_if.source                             out,
    input  logic                               cfg_we,
    input  logic [dwsp_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [dwsp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    localparam logic signed [47:0] S24_MAX = 48'sd8388607;
    localparam logic signed [47:0] S24_MIN = -48'sd8388608;
    localparam logic signed [51:0] S32_MAX = 52'sd2147483647;
    localparam logic signed [51:0] S32_MIN = -52'sd2147483648;

    logic [23:0] kp_reg, kd_reg, kis_reg, kim_reg, kil_reg, scale_reg;
    logic [22:0] ths_reg, thl_reg;

    dwsp_pkg::state_t state_reg, state_next;
    dwsp_pkg::in_item_t item_reg, item_next;
    logic side_reg, side_next;           // 0 = left wheel, 1 = right wheel
    logic [1:0] term_reg, term_next;
    logic signed [39:0] prod_reg, prod_next;
    logic neg_reg, neg_next;
    logic signed [23:0] lspd_reg, lspd_next, rspd_reg, rspd_next;
    logic signed [25:0] e_reg, e_next;
    logic signed [51:0] sum_reg, sum_next;
    logic sat_reg, sat_next;
    logic signed [31:0] lacc_reg, lacc_next, racc_reg, racc_next;
    logic signed [25:0] le1_reg, le1_next, le2_reg, le2_next;
    logic signed [25:0] re1_reg, re1_next, re2_reg, re2_next;
    logic out_valid_reg, out_valid_next;
    dwsp_pkg::out_item_t out_reg, out_next;

    dwsp_pkg::div_ctrl_t div_ctrl;
    dwsp_pkg::div_stat_t div_stat;
    logic [39:0] div_quo;
    logic [39:0] div_dividend;
    logic [15:0] div_divisor;

    // Shared multiplier operands.
    logic signed [26:0] mul_a;
    logic        [23:0] mul_b;
    logic signed [51:0] mul_p;

    logic signed [15:0] cnt_sel;
    logic signed [25:0] e1_sel, e2_sel, e_calc;
    logic [25:0] mag;
    logic [23:0] ki_sel;
    logic signed [31:0] acc_sel;
    logic signed [47:0] q_signed;
    logic signed [23:0] spd_clip;
    logic spd_sat;
    logic signed [51:0] acc_sum;
    logic signed [31:0] acc_clip;
    logic acc_sat;

    dwsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= '0; kd_reg <= '0; kis_reg <= '0; kim_reg <= '0;
            kil_reg <= '0; scale_reg <= '0;
            ths_reg <= dwsp_pkg::TH_S_RESET;
            thl_reg <= dwsp_pkg::TH_L_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                dwsp_pkg::REG_KP:    kp_reg <= cfg_data;
                dwsp_pkg::REG_KD:    kd_reg <= cfg_data;
                dwsp_pkg::REG_KI_S:  kis_reg <= cfg_data;
                dwsp_pkg::REG_KI_M:  kim_reg <= cfg_data;
                dwsp_pkg::REG_KI_L:  kil_reg <= cfg_data;
                dwsp_pkg::REG_TH_S:  ths_reg <= cfg_data[22:0];
                dwsp_pkg::REG_TH_L:  thl_reg <= cfg_data[22:0];
                dwsp_pkg::REG_SCALE: scale_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dwsp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            lacc_reg <= '0; racc_reg <= '0;
            le1_reg <= '0; le2_reg <= '0; re1_reg <= '0; re2_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            lacc_reg <= lacc_next; racc_reg <= racc_next;
            le1_reg <= le1_next; le2_reg <= le2_next;
            re1_reg <= re1_next; re2_reg <= re2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        side_reg <= side_next;
        term_reg <= term_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        lspd_reg <= lspd_next;
        rspd_reg <= rspd_next;
        e_reg    <= e_next;
        sum_reg  <= sum_next;
        sat_reg  <= sat_next;
        out_reg  <= out_next;
    end

    assign cnt_sel = side_reg ? item_reg.right_counts : item_reg.left_counts;
    assign e1_sel  = side_reg ? re1_reg : le1_reg;
    assign e2_sel  = side_reg ? re2_reg : le2_reg;
    assign acc_sel = side_reg ? racc_reg : lacc_reg;
    assign mag     = e_reg[25] ? 26'(-e_reg) : 26'(e_reg);
    assign ki_sel  = (mag < {3'b000, ths_reg}) ? kis_reg :
                     (mag < {3'b000, thl_reg}) ? kim_reg : kil_reg;

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    assign div_dividend = prod_reg[39] ? 40'(-prod_reg) : 40'(prod_reg);
    assign div_divisor  = (item_reg.interval_ms == '0) ? 16'd1 : item_reg.interval_ms;
    assign q_signed = neg_reg ? -$signed({8'd0, div_quo}) : $signed({8'd0, div_quo});
    assign spd_clip = (q_signed > S24_MAX) ? 24'sh7FFFFF :
                      (q_signed < S24_MIN) ? 24'sh800000 : q_signed[23:0];
    assign spd_sat  = (q_signed > S24_MAX) || (q_signed < S24_MIN);
    assign acc_sum  = 52'(acc_sel) + (sum_reg >>> 16);
    assign acc_clip = (acc_sum > S32_MAX) ? 32'sh7FFFFFFF :
                      (acc_sum < S32_MIN) ? 32'sh80000000 : acc_sum[31:0];
    assign acc_sat  = (acc_sum > S32_MAX) || (acc_sum < S32_MIN);

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        side_next = side_reg;
        term_next = term_reg;
        prod_next = prod_reg;
        neg_next = neg_reg;
        lspd_next = lspd_reg;
        rspd_next = rspd_reg;
        e_next = e_reg;
        e_calc = e_reg;
        sum_next = sum_reg;
        sat_next = sat_reg;
        lacc_next = lacc_reg; racc_next = racc_reg;
        le1_next = le1_reg; le2_next = le2_reg;
        re1_next = re1_reg; re2_next = re2_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        div_ctrl.start = 1'b0;
        mul_a = 27'(cnt_sel);
        mul_b = scale_reg;

        if (out_valid_reg && out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            dwsp_pkg::ST_IDLE:
            begin
                if (in.valid)
                begin
                    item_next = in.payload;
                    side_next = 1'b0;
                    sat_next = 1'b0;
                    state_next = dwsp_pkg::ST_MUL;
                end
            end
            dwsp_pkg::ST_MUL:
            begin
                prod_next = mul_p[39:0];
                neg_next = mul_p[51];
                state_next = dwsp_pkg::ST_DIV_START;
            end
            dwsp_pkg::ST_DIV_START:
            begin
                div_ctrl.start = 1'b1;
                state_next = dwsp_pkg::ST_DIV_WAIT;
            end
            dwsp_pkg::ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = dwsp_pkg::ST_SPEED;
                end
            end
            dwsp_pkg::ST_SPEED:
            begin
                if (spd_sat)
                begin
                    sat_next = 1'b1;
                end
                if (side_reg)
                begin
                    rspd_next = spd_clip;
                    side_next = 1'b0;
                    state_next = dwsp_pkg::ST_ERR;
                end
                else
                begin
                    lspd_next = spd_clip;
                    side_next = 1'b1;
                    state_next = dwsp_pkg::ST_MUL;
                end
            end
            dwsp_pkg::ST_ERR:
            begin
                // The left motor is mounted reversed.
                if (side_reg)
                begin
                    e_calc = 26'(item_reg.right_target) - 26'(rspd_reg);
                end
                else
                begin
                    e_calc = -26'(item_reg.left_target) - 26'(lspd_reg);
                end
                e_next = e_calc;
                sum_next = '0;
                term_next = 2'd0;
                state_next = dwsp_pkg::ST_TERM;
            end
            dwsp_pkg::ST_TERM:
            begin
                case (term_reg)
                    2'd0:
                    begin
                        mul_a = 27'(e_reg) - 27'(e1_sel);
                        mul_b = kp_reg;
                    end
                    2'd1:
                    begin
                        mul_a = 27'(e_reg);
                        mul_b = ki_sel;
                    end
                    default:
                    begin
                        mul_a = 27'(e_reg) - 27'(e1_sel) - 27'(e1_sel) + 27'(e2_sel);
                        mul_b = kd_reg;
                    end
                endcase
                sum_next = sum_reg + mul_p;
                term_next = term_reg + 2'd1;
                if (term_reg == 2'd2)
                begin
                    state_next = dwsp_pkg::ST_ACC;
                end
            end
            dwsp_pkg::ST_ACC:
            begin
                if (acc_sat)
                begin
                    sat_next = 1'b1;
                end
                if (side_reg)
                begin
                    racc_next = acc_clip;
                    re2_next = re1_reg;
                    re1_next = e_reg;
                    state_next = dwsp_pkg::ST_OUT;
                end
                else
                begin
                    lacc_next = acc_clip;
                    le2_next = le1_reg;
                    le1_next = e_reg;
                    side_next = 1'b1;
                    state_next = dwsp_pkg::ST_ERR;
                end
            end
            dwsp_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out.ready)
                begin
                    out_next.left_drive = lacc_reg;
                    out_next.right_drive = racc_reg;
                    out_next.left_speed = lspd_reg;
                    out_next.right_speed = rspd_reg;
                    out_next.saturated = sat_reg;
                    out_valid_next = 1'b1;
                    state_next = dwsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dwsp_pkg::ST_IDLE;
            end
        endcase
    end

    assign in.ready = (state_reg == dwsp_pkg::ST_IDLE);
    assign out.valid = out_valid_reg;
    assign out.payload = out_reg;
endmodule

@@ hdl/dwsp_checker.sv @@
// Port-level checker for the dual wheel speed PID, bound to the top level.
`timescale 1ns / 1ps
module dwsp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    // The block takes one request at a time and is busy right after one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // No result can appear in the cycle right after an input is taken.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result too early");

    // A pending result stays until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
endmodule

bind dual_wheel_speed_pid dwsp_checker u_dwsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready)
);
